### sv/line_edit_buffer_macros.svh
// Assertion macros for the line edit buffer.
`ifndef LINE_EDIT_BUFFER_MACROS_SVH
`define LINE_EDIT_BUFFER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LEB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line_edit_buffer assertion failed");
`define LEB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line_edit_buffer assertion failed");
`else
`define LEB_ASSERT_SAME(lbl, ante, cons)
`define LEB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### sv/leb_pkg.sv
package leb_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int CMD_W   = 4;
  localparam int KEY_W   = 8;
  localparam int PROBE_W = 6;
  localparam int POS_W   = 6;
  localparam int LIMIT_W = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic [CMD_W-1:0] CMD_CHAR      = 4'd0;
  localparam logic [CMD_W-1:0] CMD_ENTER     = 4'd1;
  localparam logic [CMD_W-1:0] CMD_BACKSPACE = 4'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE    = 4'd3;
  localparam logic [CMD_W-1:0] CMD_LEFT      = 4'd4;
  localparam logic [CMD_W-1:0] CMD_RIGHT     = 4'd5;
  localparam logic [CMD_W-1:0] CMD_HOME      = 4'd6;
  localparam logic [CMD_W-1:0] CMD_END       = 4'd7;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd8;

  localparam logic [KEY_W-1:0] CHAR_LO = 8'h20;
  localparam logic [KEY_W-1:0] CHAR_HI = 8'h7E;

  typedef struct packed {
    logic shift_rd;
    logic put_wr;
    logic probe_rd;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_insert;
    logic has_moves;
    logic last_move;
  } dp_stat_t;

endpackage

### sv/leb_if.sv
interface leb_in_if;
  import leb_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [KEY_W-1:0]   key_char;
  logic [PROBE_W-1:0] probe_index;

  modport source(output valid, output cmd, output key_char, output probe_index,
                 input ready);
  modport sink(input valid, input cmd, input key_char, input probe_index,
               output ready);
endinterface

interface leb_out_if;
  import leb_pkg::*;

  logic             valid;
  logic             ready;
  logic             handled;
  logic [POS_W-1:0] cursor_pos;
  logic [POS_W-1:0] line_length;
  logic [KEY_W-1:0] probe_char;

  modport source(output valid, output handled, output cursor_pos, output line_length,
                 output probe_char, input ready);
  modport sink(input valid, input handled, input cursor_pos, input line_length,
               input probe_char, output ready);
endinterface

### sv/leb_ctrl.sv
module leb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  leb_pkg::dp_stat_t  stat,
  output leb_pkg::ctl_cmd_t  cmd,
  output logic               in_take
);
  import leb_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SHIFT = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_PUT   = 3'd3;
  localparam logic [2:0] ST_PROBE = 3'd4;
  localparam logic [2:0] ST_LOAD  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_take   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_take) state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (stat.has_moves) begin
          cmd.shift_rd = 1'b1;
          if (stat.last_move) state_nxt = ST_DRAIN;
        end else begin
          state_nxt = stat.is_insert ? ST_PUT : ST_PROBE;
        end
      end
      ST_DRAIN: state_nxt = stat.is_insert ? ST_PUT : ST_PROBE;
      ST_PUT: begin
        cmd.put_wr = 1'b1;
        state_nxt  = ST_PROBE;
      end
      ST_PROBE: begin
        cmd.probe_rd = 1'b1;
        state_nxt    = ST_LOAD;
      end
      ST_LOAD: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### sv/leb_datapath.sv
module leb_datapath #(
  parameter int DEPTH = leb_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [leb_pkg::LIMIT_W-1:0] cfg_wdata,
  input  logic                        in_take,
  input  logic [leb_pkg::CMD_W-1:0]   in_cmd,
  input  logic [leb_pkg::KEY_W-1:0]   in_key,
  input  logic [leb_pkg::PROBE_W-1:0] in_probe,
  input  leb_pkg::ctl_cmd_t           cmd,
  output leb_pkg::dp_stat_t           stat,
  output logic                        out_handled,
  output logic [leb_pkg::POS_W-1:0]   out_cursor,
  output logic [leb_pkg::POS_W-1:0]   out_length,
  output logic [leb_pkg::KEY_W-1:0]   out_char
);
  import leb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int WW = AW + 8;

  logic [KEY_W-1:0]   mem [DEPTH];

  logic [LIMIT_W-1:0] limit_r;
  logic [AW-1:0]      cursor_r, length_r;
  logic [KEY_W-1:0]   char_r;
  logic [PROBE_W-1:0] probe_r;
  logic [AW-1:0]      src_r, cnt_r, put_addr_r, wr_addr_r;
  logic               up_r, ins_r, hand_r, pend_r, hit_r;
  logic [KEY_W-1:0]   rdata_r;
  logic               out_handled_r;
  logic [POS_W-1:0]   out_cursor_r, out_length_r;
  logic [KEY_W-1:0]   out_char_r;

  logic [WW-1:0]      lim_w;
  logic [AW-1:0]      cap, len_c, cur_c;
  logic [AW-1:0]      cur_n, len_n, moves, src_n;
  logic               up_n, ins_n, hand_n, printable;
  logic [AW-1:0]      probe_addr;

  always_comb begin
    lim_w = WW'(limit_r);
    if (lim_w == '0) lim_w = WW'(1);
    if (lim_w > WW'(DEPTH)) lim_w = WW'(DEPTH);
    cap   = AW'(lim_w - WW'(1));
    len_c = (length_r > cap) ? cap : length_r;
    cur_c = (cursor_r > len_c) ? len_c : cursor_r;
  end

  assign printable  = (in_key >= CHAR_LO) && (in_key <= CHAR_HI);
  assign probe_addr = AW'(probe_r);

  always_comb begin
    cur_n  = cur_c;
    len_n  = len_c;
    moves  = '0;
    src_n  = '0;
    up_n   = 1'b0;
    ins_n  = 1'b0;
    hand_n = 1'b1;
    case (in_cmd)
      CMD_CHAR: begin
        if (!printable) begin
          hand_n = 1'b0;
        end else if (cur_c < cap) begin
          ins_n = 1'b1;
          len_n = (len_c < cap) ? len_c + AW'(1) : len_c;
          moves = len_n - AW'(1) - cur_c;
          src_n = len_n - AW'(1) - AW'(1);
          cur_n = cur_c + AW'(1);
        end
      end
      CMD_BACKSPACE: begin
        if (cur_c != '0) begin
          moves = len_c - cur_c;
          src_n = cur_c;
          up_n  = 1'b1;
          len_n = len_c - AW'(1);
          cur_n = cur_c - AW'(1);
        end
      end
      CMD_DELETE: begin
        if (cur_c < len_c) begin
          moves = len_c - AW'(1) - cur_c;
          src_n = cur_c + AW'(1);
          up_n  = 1'b1;
          len_n = len_c - AW'(1);
        end
      end
      CMD_LEFT:  if (cur_c != '0) cur_n = cur_c - AW'(1);
      CMD_RIGHT: if (cur_c < len_c) cur_n = cur_c + AW'(1);
      CMD_HOME:  cur_n = '0;
      CMD_END:   cur_n = len_c;
      CMD_CLEAR: begin
        cur_n = '0;
        len_n = '0;
      end
      CMD_ENTER: hand_n = 1'b0;
      default:   hand_n = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_RESET;
      cursor_r <= '0;
      length_r <= '0;
      pend_r   <= 1'b0;
    end else begin
      if (cfg_we) limit_r <= cfg_wdata;
      if (in_take) begin
        cursor_r <= cur_n;
        length_r <= len_n;
      end else begin
        // keep length and cursor within the current limit
        cursor_r <= cur_c;
        length_r <= len_c;
      end
      pend_r <= cmd.shift_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      char_r     <= in_key;
      probe_r    <= in_probe;
      src_r      <= src_n;
      cnt_r      <= moves;
      up_r       <= up_n;
      ins_r      <= ins_n;
      put_addr_r <= cur_c;
      hand_r     <= hand_n;
    end else if (cmd.shift_rd) begin
      src_r     <= up_r ? src_r + AW'(1) : src_r - AW'(1);
      cnt_r     <= cnt_r - AW'(1);
      wr_addr_r <= up_r ? src_r - AW'(1) : src_r + AW'(1);
    end
    if (cmd.probe_rd) hit_r <= WW'(probe_r) < WW'(length_r);
  end

  // store with one write port and one registered read port: one write and one read per cycle
  always_ff @(posedge clk) begin
    if (pend_r) mem[wr_addr_r] <= rdata_r;
    else if (cmd.put_wr) mem[put_addr_r] <= char_r;
    if (cmd.shift_rd) rdata_r <= mem[src_r];
    else if (cmd.probe_rd) rdata_r <= mem[probe_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_handled_r <= hand_r;
      out_cursor_r  <= POS_W'(cursor_r);
      out_length_r  <= POS_W'(length_r);
      out_char_r    <= hit_r ? rdata_r : '0;
    end
  end

  assign stat.is_insert = ins_r;
  assign stat.has_moves = (cnt_r != '0);
  assign stat.last_move = (cnt_r == AW'(1));

  assign out_handled = out_handled_r;
  assign out_cursor  = out_cursor_r;
  assign out_length  = out_length_r;
  assign out_char    = out_char_r;

endmodule

### sv/line_edit_buffer.sv
// channel   dir  handshake      payload
// in_chan   in   valid/ready    cmd, key_char, probe_index
// out_chan  out  valid/ready    handled, cursor_pos, line_length, probe_char
// cfg       in   cfg_we         cfg_wdata (line_limit)
//
// An item passes the shift step, with m moves when m > 0 characters move, a drain
// step after any moves, a put step for an insert, and the probe and load steps;
// m is at most capacity-1, one move per cycle; in_ready stays low until the load.
// Reset is synchronous; the character store is not cleared.
// A held result stalls the next item only at its final load step.
`include "line_edit_buffer_macros.svh"

module line_edit_buffer #(
  parameter int DEPTH = leb_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [leb_pkg::LIMIT_W-1:0] cfg_wdata,
  leb_in_if.sink                      in_chan,
  leb_out_if.source                   out_chan
);
  import leb_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;
  logic     in_take;

  leb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (dp_stat),
    .cmd       (ctl_cmd),
    .in_take   (in_take)
  );

  leb_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_take     (in_take),
    .in_cmd      (in_chan.cmd),
    .in_key      (in_chan.key_char),
    .in_probe    (in_chan.probe_index),
    .cmd         (ctl_cmd),
    .stat        (dp_stat),
    .out_handled (out_chan.handled),
    .out_cursor  (out_chan.cursor_pos),
    .out_length  (out_chan.line_length),
    .out_char    (out_chan.probe_char)
  );

  `LEB_ASSERT_NEXT(a_busy_after_take, in_take, !in_chan.ready)
  `LEB_ASSERT_NEXT(a_put_then_probe, ctl_cmd.put_wr, ctl_cmd.probe_rd)
  `LEB_ASSERT_NEXT(a_load_sets_valid, ctl_cmd.load_out, out_chan.valid)
  `LEB_ASSERT_SAME(a_no_take_while_shift, ctl_cmd.shift_rd, !in_chan.ready)

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import leb_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd9;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;
  localparam logic [KEY_W-1:0] KEY_NUL = 8'h00;
  localparam logic [KEY_W-1:0] KEY_LF  = 8'h0A;
  localparam logic [KEY_W-1:0] KEY_CR  = 8'h0D;
  localparam logic [KEY_W-1:0] KEY_US  = 8'h1F;
  localparam logic [KEY_W-1:0] KEY_DEL = 8'h7F;
  localparam int ITEMS_PER_PHASE = 85;
  localparam int HOLD_AT_ITEM = 150;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [KEY_W-1:0]   key;
    logic [PROBE_W-1:0] probe;
  } edit_item_t;

  typedef struct packed {
    logic             handled;
    logic [POS_W-1:0] cursor;
    logic [POS_W-1:0] length;
    logic [KEY_W-1:0] probe_char;
  } line_view_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  leb_in_if  in_if();
  leb_out_if out_if();

  line_edit_buffer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // line state as the block should hold it
  logic [KEY_W-1:0]   line_chars [DEPTH_DEF];
  int                 cur_pos;
  int                 line_len;
  logic [LIMIT_W-1:0] line_limit_reg;

  edit_item_t pending_edits [$];
  line_view_t expected_views [$];
  edit_item_t offered;

  int  items_queued = 0;
  int  items_sent = 0;
  int  results_checked = 0;
  int  mismatches = 0;
  int  full_inserts = 0;
  int  unhandled_keys = 0;
  int  limit_writes = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  idle_en = 1'b1;
  bit  hold_off;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int line_cap();
    int lim;
    lim = line_limit_reg;
    if (lim < 1) lim = 1;
    if (lim > DEPTH_DEF) lim = DEPTH_DEF;
    return lim - 1;
  endfunction

  function automatic void clamp_line();
    int cap;
    cap = line_cap();
    if (line_len > cap) line_len = cap;
    if (cur_pos > line_len) cur_pos = line_len;
  endfunction

  function automatic void remove_char(int pos);
    for (int i = pos; i + 1 < line_len; i++) line_chars[i] = line_chars[i + 1];
    line_len = line_len - 1;
  endfunction

  function automatic line_view_t apply_edit(edit_item_t it);
    line_view_t v;
    int cap;
    clamp_line();
    cap = line_cap();
    v.handled = 1'b1;
    case (it.cmd)
      CMD_CHAR: begin
        if (it.key >= CHAR_LO && it.key <= CHAR_HI) begin
          if (cur_pos >= cap) begin
            cur_pos = cap;
          end else begin
            if (line_len < cap) line_len = line_len + 1;
            else full_inserts++;
            for (int i = line_len - 1; i > cur_pos; i--) line_chars[i] = line_chars[i - 1];
            line_chars[cur_pos] = it.key;
            cur_pos = cur_pos + 1;
            if (cur_pos > cap) cur_pos = cap;
          end
        end else begin
          v.handled = 1'b0;
        end
      end
      CMD_BACKSPACE: begin
        if (cur_pos > 0) begin
          remove_char(cur_pos - 1);
          cur_pos = cur_pos - 1;
        end
      end
      CMD_DELETE: if (cur_pos < line_len) remove_char(cur_pos);
      CMD_LEFT:   if (cur_pos > 0) cur_pos = cur_pos - 1;
      CMD_RIGHT:  if (cur_pos < line_len) cur_pos = cur_pos + 1;
      CMD_HOME:   cur_pos = 0;
      CMD_END:    cur_pos = line_len;
      CMD_CLEAR: begin
        cur_pos = 0;
        line_len = 0;
      end
      default:    v.handled = 1'b0;
    endcase
    if (!v.handled) unhandled_keys++;
    v.cursor = POS_W'(cur_pos);
    v.length = POS_W'(line_len);
    v.probe_char = (it.probe < line_len) ? line_chars[it.probe] : KEY_NUL;
    return v;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR t=%0t item %0d: %s got %0d, expected %0d",
             $time, results_checked, what, got, want);
    mismatches++;
  endtask

  task automatic push_edit(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                           logic [PROBE_W-1:0] probe);
    edit_item_t it;
    it.cmd = cmd;
    it.key = key;
    it.probe = probe;
    pending_edits.push_back(it);
    items_queued++;
  endtask

  function automatic logic [PROBE_W-1:0] pick_probe();
    if ($urandom_range(0, 1) == 0) return PROBE_W'($urandom_range(0, 63));
    return PROBE_W'($urandom_range(0, line_cap()));
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_edits.size() != 0 || expected_views.size() != 0 || in_if.valid);
    repeat (8) @(negedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.cmd <= CMD_ENTER;
      in_if.key_char <= KEY_NUL;
      in_if.probe_index <= '0;
      cur_pos = 0;
      line_len = 0;
      line_limit_reg = LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        line_limit_reg = cfg_wdata;
        clamp_line();
      end
      if (in_if.valid && in_if.ready) begin
        expected_views.push_back(apply_edit(offered));
        items_sent++;
        if (idle_en && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 17);
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          in_if.valid <= 1'b0;
          gap_left--;
        end else if (pending_edits.size() != 0) begin
          offered = pending_edits.pop_front();
          in_if.valid <= 1'b1;
          in_if.cmd <= offered.cmd;
          in_if.key_char <= offered.key;
          in_if.probe_index <= offered.probe;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    line_view_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_views.size() == 0) begin
          report_mismatch("unexpected result, handled", out_if.handled, 0);
        end else begin
          want = expected_views.pop_front();
          if (out_if.handled !== want.handled)
            report_mismatch("handled", out_if.handled, want.handled);
          if (out_if.cursor_pos !== want.cursor)
            report_mismatch("cursor_pos", out_if.cursor_pos, want.cursor);
          if (out_if.line_length !== want.length)
            report_mismatch("line_length", out_if.line_length, want.length);
          if (out_if.probe_char !== want.probe_char)
            report_mismatch("probe_char", out_if.probe_char, want.probe_char);
        end
        results_checked++;
      end
      if (stall_left > 0) stall_left--;
      else if (idle_en && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 17);
      out_if.ready <= !hold_off && stall_left == 0;
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    hold_off = 1'b0;
    do @(negedge clk);
    while (items_sent < HOLD_AT_ITEM);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #10_000_000;
    $display("timeout: %0d items sent, %0d results checked", items_sent, results_checked);
    $display("line_edit_buffer: mismatch");
    $finish;
  end

  initial begin
    logic [LIMIT_W-1:0] limits [12];
    logic [CMD_W-1:0]   cmd;
    logic [KEY_W-1:0]   key;
    int                 target;
    int                 roll;
    int                 run;

    limits = '{7'd64, 7'd10, 7'd3, 7'd1, 7'd0, 7'd2, 7'd127, 7'd40, 7'd64, 7'd5,
               7'd100, 7'd64};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty-line edge moves, rejected keys, inserts at the end and in the middle
    push_edit(CMD_BACKSPACE, 8'hFF, 6'd0);
    push_edit(CMD_LEFT, 8'h00, 6'd0);
    push_edit(CMD_DELETE, 8'h55, 6'd63);
    push_edit(CMD_RIGHT, 8'hAA, 6'd0);
    push_edit(CMD_ENTER, KEY_LF, 6'd0);
    push_edit(CMD_CHAR, KEY_LF, 6'd0);
    push_edit(CMD_CHAR, KEY_CR, 6'd0);
    push_edit(CMD_CHAR, KEY_NUL, 6'd0);
    push_edit(CMD_CHAR, KEY_US, 6'd0);
    push_edit(CMD_CHAR, KEY_DEL, 6'd0);
    push_edit(CMD_CHAR, 8'hFF, 6'd0);
    push_edit(CMD_CHAR, CHAR_LO, 6'd0);
    push_edit(CMD_CHAR, CHAR_HI, 6'd1);
    push_edit(CMD_CHAR, 8'h41, 6'd2);
    push_edit(CMD_LEFT, 8'h00, 6'd2);
    push_edit(CMD_LEFT, 8'h00, 6'd1);
    push_edit(CMD_CHAR, 8'h42, 6'd1);
    push_edit(CMD_HOME, 8'h00, 6'd63);
    push_edit(CMD_DELETE, 8'h00, 6'd0);
    push_edit(CMD_END, 8'h00, 6'd1);
    push_edit(CMD_BACKSPACE, 8'h00, 6'd2);
    push_edit(CMD_RIGHT, 8'h00, 6'd0);
    push_edit(CMD_SPARE_LO, 8'h41, 6'd0);
    push_edit(CMD_SPARE_HI, 8'h41, 6'd0);
    push_edit(CMD_CLEAR, 8'h00, 6'd0);

    foreach (limits[p]) begin
      wait_idle();
      idle_en = (p % 3 != 2) && (p != $size(limits) - 1);
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_wdata <= limits[p];
      @(posedge clk);
      cfg_we <= 1'b0;
      limit_writes++;
      @(negedge clk);

      target = items_queued + ITEMS_PER_PHASE;
      while (items_queued < target) begin
        if ($urandom_range(0, 5) == 0) begin
          // typing burst that can fill the line and push past it
          run = $urandom_range(3, line_cap() + 3);
          if (run > target - items_queued) run = target - items_queued;
          repeat (run) push_edit(CMD_CHAR, KEY_W'($urandom_range(CHAR_LO, CHAR_HI)),
                                 pick_probe());
        end else begin
          roll = $urandom_range(0, 99);
          key = KEY_W'($urandom_range(0, 255));
          if (roll < 50) begin
            cmd = CMD_CHAR;
            key = KEY_W'($urandom_range(CHAR_LO, CHAR_HI));
          end
          else if (roll < 55) cmd = CMD_CHAR;
          else if (roll < 65) cmd = CMD_BACKSPACE;
          else if (roll < 72) cmd = CMD_DELETE;
          else if (roll < 80) cmd = CMD_LEFT;
          else if (roll < 87) cmd = CMD_RIGHT;
          else if (roll < 91) cmd = CMD_HOME;
          else if (roll < 95) cmd = CMD_END;
          else if (roll < 97) cmd = CMD_CLEAR;
          else if (roll < 98) cmd = CMD_ENTER;
          else cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
          push_edit(cmd, key, pick_probe());
        end
      end
    end

    wait_idle();
    repeat (16) @(posedge clk);
    $display("%0d edits sent, %0d results checked over %0d line_limit settings",
             items_sent, results_checked, limit_writes);
    $display("%0d inserts into a full line, %0d keys passed on unhandled",
             full_inserts, unhandled_keys);
    if (mismatches == 0) begin
      $display("line_edit_buffer: match");
    end else begin
      $display("%0d field mismatches", mismatches);
      $display("line_edit_buffer: mismatch");
    end
    $finish;
  end

endmodule
